@@ src/tcvl_pkg.sv @@
// Shared types and constants of the triangle cull and vertex light core.
package tcvl_pkg;

    // controller phase codes, carried to the datapath in the command
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_READ  = 4'd1;
    localparam logic [3:0] ST_DIFF  = 4'd2;
    localparam logic [3:0] ST_CROSS = 4'd3;
    localparam logic [3:0] ST_MAG   = 4'd4;
    localparam logic [3:0] ST_SQ    = 4'd5;
    localparam logic [3:0] ST_SQRT  = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_SHADE = 4'd8;
    localparam logic [3:0] ST_LIGHT = 4'd9;
    localparam logic [3:0] ST_EMIT  = 4'd10;

    // configuration register indexes
    localparam logic [2:0] CFG_LIGHT_DIR = 3'd0;
    localparam logic [2:0] CFG_AMBIENT   = 3'd1;
    localparam logic [2:0] CFG_LDIFFUSE  = 3'd2;
    localparam logic [2:0] CFG_LSPECULAR = 3'd3;
    localparam logic [2:0] CFG_MDIFFUSE  = 3'd4;
    localparam logic [2:0] CFG_MSPECULAR = 3'd5;

    localparam logic [47:0] RST_LIGHT_DIR = 48'd49152;
    localparam logic [47:0] RST_ONES      = 48'd70369817935872;

    localparam int ONE_Q14 = 16384;

    localparam int SQRT_STEPS = 32;  // result bits of the square root
    localparam int DIV_STEPS  = 16;  // quotient bits of the normalize divide
    localparam int LIGHT_STEPS = 4;  // multiplies per color channel

    typedef struct packed {
        logic [3:0] op;     // current phase
        logic       load;   // write a vertex from the input beat
        logic       start;  // latch the indices of a draw beat
        logic [5:0] cnt;    // step inside the phase
        logic [1:0] comp;   // component or channel
        logic [1:0] vtx;    // vertex being lit
    } t_cmd;

    typedef struct packed {
        logic out_free;     // output register can take a result
    } t_stat;

endpackage

@@ src/tcvl_ram.sv @@
// Generic single write port RAM with one registered read port.
module tcvl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ src/tcvl_ctrl.sv @@
// Controller state machine: sequences a draw through fetch, normal, shade and light.
module tcvl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_opcode,
    output logic           o_in_ready,
    input  tcvl_pkg::t_stat i_stat,
    output tcvl_pkg::t_cmd  o_cmd
);

    logic [3:0] r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic [1:0] r_comp, n_comp;
    logic [1:0] r_vtx, n_vtx;
    logic       accept;

    assign o_in_ready = (r_state == tcvl_pkg::ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // drive command
    always_comb begin
        o_cmd       = '0;
        o_cmd.op    = r_state;
        o_cmd.cnt   = r_cnt;
        o_cmd.comp  = r_comp;
        o_cmd.vtx   = r_vtx;
        o_cmd.load  = accept && !i_opcode;
        o_cmd.start = accept && i_opcode;
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + 6'd1;
        n_comp  = r_comp;
        n_vtx   = r_vtx;
        case (r_state)
            tcvl_pkg::ST_IDLE: begin
                n_cnt  = '0;
                n_comp = '0;
                n_vtx  = '0;
                if (accept && i_opcode) begin
                    n_state = tcvl_pkg::ST_READ;
                end
            end
            tcvl_pkg::ST_READ: begin
                if (r_cnt == 6'd3) begin
                    n_state = tcvl_pkg::ST_DIFF;
                end
            end
            tcvl_pkg::ST_DIFF: begin
                n_cnt   = '0;
                n_state = tcvl_pkg::ST_CROSS;
            end
            tcvl_pkg::ST_CROSS: begin
                if (r_cnt == 6'd5) begin
                    n_state = tcvl_pkg::ST_MAG;
                end
            end
            tcvl_pkg::ST_MAG: begin
                n_cnt   = '0;
                n_state = tcvl_pkg::ST_SQ;
            end
            tcvl_pkg::ST_SQ: begin
                if (r_cnt == 6'd2) begin
                    n_cnt   = '0;
                    n_state = tcvl_pkg::ST_SQRT;
                end
            end
            tcvl_pkg::ST_SQRT: begin
                if (r_cnt == 6'(tcvl_pkg::SQRT_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_comp  = '0;
                    n_state = tcvl_pkg::ST_DIV;
                end
            end
            tcvl_pkg::ST_DIV: begin
                if (r_cnt == 6'(tcvl_pkg::DIV_STEPS)) begin
                    n_cnt  = '0;
                    n_comp = r_comp + 2'd1;
                    if (r_comp == 2'd2) begin
                        n_state = tcvl_pkg::ST_SHADE;
                    end
                end
            end
            tcvl_pkg::ST_SHADE: begin
                if (r_cnt == 6'd2) begin
                    n_cnt   = '0;
                    n_comp  = '0;
                    n_vtx   = '0;
                    n_state = tcvl_pkg::ST_LIGHT;
                end
            end
            tcvl_pkg::ST_LIGHT: begin
                if (r_cnt == 6'(tcvl_pkg::LIGHT_STEPS - 1)) begin
                    n_cnt  = '0;
                    n_comp = r_comp + 2'd1;
                    if (r_comp == 2'd2) begin
                        n_comp  = '0;
                        n_state = tcvl_pkg::ST_EMIT;
                    end
                end
            end
            tcvl_pkg::ST_EMIT: begin
                n_cnt = '0;
                if (i_stat.out_free) begin
                    n_vtx   = r_vtx + 2'd1;
                    n_state = (r_vtx == 2'd2) ? tcvl_pkg::ST_IDLE : tcvl_pkg::ST_LIGHT;
                end
            end
            default: begin
                n_state = tcvl_pkg::ST_IDLE;
            end
        endcase
    end

    // advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcvl_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_comp  <= '0;
            r_vtx   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_comp  <= n_comp;
            r_vtx   <= n_vtx;
        end
    end

endmodule

@@ src/tcvl_dp.sv @@
// Datapath: vertex store, config registers, normal, shade and per-vertex lighting.
module tcvl_dp #(
    parameter int VERTEX_SLOTS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tcvl_pkg::t_cmd      i_cmd,
    output tcvl_pkg::t_stat     o_stat,
    input  logic [4:0]          i_vertex_index,
    input  logic signed [15:0]  i_load_x,
    input  logic signed [15:0]  i_load_y,
    input  logic signed [15:0]  i_load_z,
    input  logic [14:0]         i_load_red,
    input  logic [14:0]         i_load_green,
    input  logic [14:0]         i_load_blue,
    input  logic [4:0]          i_first_index,
    input  logic [4:0]          i_second_index,
    input  logic [4:0]          i_third_index,
    input  logic                i_cfg_valid,
    input  logic [2:0]          i_cfg_index,
    input  logic [47:0]         i_cfg_data,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic signed [15:0]  o_screen_x,
    output logic signed [15:0]  o_screen_y,
    output logic [14:0]         o_shaded_red,
    output logic [14:0]         o_shaded_green,
    output logic [14:0]         o_shaded_blue,
    output logic                o_front_facing,
    output logic                o_last_of_triangle
);

    localparam int AW = $clog2(VERTEX_SLOTS);
    localparam int IW = (AW > 5) ? AW : 5;

    // config registers
    logic [47:0] r_ldir, r_amb, r_ldif, r_lspc, r_mdif, r_mspc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ldir <= tcvl_pkg::RST_LIGHT_DIR;
            r_amb  <= '0;
            r_ldif <= tcvl_pkg::RST_ONES;
            r_lspc <= '0;
            r_mdif <= tcvl_pkg::RST_ONES;
            r_mspc <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tcvl_pkg::CFG_LIGHT_DIR: r_ldir <= i_cfg_data;
                tcvl_pkg::CFG_AMBIENT:   r_amb  <= i_cfg_data;
                tcvl_pkg::CFG_LDIFFUSE:  r_ldif <= i_cfg_data;
                tcvl_pkg::CFG_LSPECULAR: r_lspc <= i_cfg_data;
                tcvl_pkg::CFG_MDIFFUSE:  r_mdif <= i_cfg_data;
                tcvl_pkg::CFG_MSPECULAR: r_mspc <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // vertex store
    logic [IW-1:0] wext, rext;
    logic [AW-1:0] waddr, raddr;
    logic          we;
    logic [92:0]   rdata;
    logic [4:0]    r_idx [3];
    logic [2:0]    r_inr;
    logic [4:0]    rd_idx;

    assign wext   = IW'(i_vertex_index);
    assign waddr  = wext[AW-1:0];
    assign we     = i_cmd.load && (32'(i_vertex_index) < VERTEX_SLOTS);
    assign rd_idx = r_idx[(i_cmd.cnt[1:0] == 2'd3) ? 2'd0 : i_cmd.cnt[1:0]];
    assign rext   = IW'(rd_idx);
    assign raddr  = rext[AW-1:0];

    tcvl_ram #(
        .WIDTH(93),
        .DEPTH(VERTEX_SLOTS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata({i_load_x, i_load_y, i_load_z, i_load_red, i_load_green, i_load_blue}),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // draw working registers
    logic signed [15:0] r_p   [3][3];
    logic [14:0]        r_vc  [3][3];
    logic signed [16:0] r_a   [3];
    logic signed [16:0] r_b   [3];
    logic signed [33:0] r_pacc;
    logic signed [34:0] r_n   [3];
    logic [29:0]        r_mag [3];
    logic [2:0]         r_neg;
    logic               r_front;
    logic [61:0]        r_sq;
    logic [62:0]        r_x, r_res;
    logic [30:0]        r_len;
    logic [46:0]        r_rem, r_dsh;
    logic [15:0]        r_q;
    logic signed [15:0] r_u   [3];
    logic signed [33:0] r_sacc;
    logic signed [19:0] r_shade;
    logic [18:0]        r_d, r_s;
    logic [19:0]        r_e;
    logic [14:0]        r_col [3];

    // cross product multiplier operands
    logic [1:0]         ca_i, cb_i;
    logic signed [33:0] cprod;
    always_comb begin
        ca_i = 2'd0;
        cb_i = 2'd0;
        case (i_cmd.cnt[2:0])
            3'd0: begin ca_i = 2'd1; cb_i = 2'd2; end
            3'd1: begin ca_i = 2'd2; cb_i = 2'd1; end
            3'd2: begin ca_i = 2'd2; cb_i = 2'd0; end
            3'd3: begin ca_i = 2'd0; cb_i = 2'd2; end
            3'd4: begin ca_i = 2'd0; cb_i = 2'd1; end
            3'd5: begin ca_i = 2'd1; cb_i = 2'd0; end
            default: ;
        endcase
    end
    assign cprod = r_a[ca_i] * r_b[cb_i];

    // magnitudes and prescale
    logic [34:0] absn [3];
    logic [34:0] maxm;
    logic [2:0]  sh;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            absn[i] = r_n[i][34] ? 35'(-r_n[i]) : 35'(r_n[i]);
        end
        maxm = absn[0];
        if (absn[1] > maxm) maxm = absn[1];
        if (absn[2] > maxm) maxm = absn[2];
        if (maxm[34])      sh = 3'd5;
        else if (maxm[33]) sh = 3'd4;
        else if (maxm[32]) sh = 3'd3;
        else if (maxm[31]) sh = 3'd2;
        else if (maxm[30]) sh = 3'd1;
        else               sh = 3'd0;
    end

    // square of one magnitude
    logic [59:0] sqp;
    logic [61:0] sqsum;
    assign sqp   = r_mag[i_cmd.cnt[1:0]] * r_mag[i_cmd.cnt[1:0]];
    assign sqsum = r_sq + 62'(sqp);

    // one square root step
    logic [62:0] sbit, strial;
    assign sbit   = 63'(1) << (6'd62 - {i_cmd.cnt[4:0], 1'b0});
    assign strial = r_res + sbit;

    // one divide step
    logic [45:0] dnum;
    logic        dge;
    logic [15:0] dq_next;
    logic [15:0] dq_clamp;
    assign dnum     = {1'b0, r_mag[i_cmd.comp], 15'd0} + 46'(r_len);
    assign dge      = (r_rem >= r_dsh);
    assign dq_next  = {r_q[14:0], dge};
    assign dq_clamp = (dq_next > 16'(tcvl_pkg::ONE_Q14)) ? 16'(tcvl_pkg::ONE_Q14) : dq_next;

    // shade accumulation
    logic signed [15:0] ldir_f;
    logic signed [31:0] sprod;
    logic signed [33:0] ssum, sabs;
    logic [33:0]        srnd;
    always_comb begin
        ldir_f = $signed(r_ldir[32 - 16 * i_cmd.cnt[1:0] +: 16]);
        sprod  = ldir_f * r_u[i_cmd.cnt[1:0]];
        ssum   = r_sacc + 34'(sprod);
        sabs   = ssum[33] ? -ssum : ssum;
        srnd   = (34'(sabs) + 34'd8192) >> 14;
    end

    // lighting multiplier, one operand pair per step
    logic signed [19:0] la, lb;
    logic signed [39:0] lprod;
    logic [39:0]        lup, labs, lrnd;
    logic signed [25:0] lf;
    logic signed [27:0] ltot;
    logic [15:0]        fsel;
    always_comb begin
        la = '0;
        lb = '0;
        fsel = 16'd0;
        case (i_cmd.cnt[1:0])
            2'd0: begin
                la = 20'(r_ldif[32 - 16 * i_cmd.comp +: 16]);
                lb = 20'(r_mdif[32 - 16 * i_cmd.comp +: 16]);
            end
            2'd1: begin
                la = 20'(r_lspc[32 - 16 * i_cmd.comp +: 16]);
                lb = 20'(r_mspc[32 - 16 * i_cmd.comp +: 16]);
            end
            2'd2: begin
                la = 20'(r_d);
                lb = 20'(r_vc[i_cmd.vtx][i_cmd.comp]);
            end
            2'd3: begin
                la = r_e;
                lb = r_shade;
            end
            default: ;
        endcase
        lprod = la * lb;
        lup   = (40'(lprod) + 40'd8192) >> 14;
        labs  = lprod[39] ? 40'(-lprod) : 40'(lprod);
        lrnd  = (labs + 40'd8192) >> 14;
        lf    = lprod[39] ? -$signed(26'(lrnd)) : $signed(26'(lrnd));
        fsel  = r_amb[32 - 16 * i_cmd.comp +: 16];
        ltot  = $signed({12'd0, fsel}) + 28'(lf) + $signed({9'd0, r_s});
    end

    // sequence the datapath registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            tcvl_pkg::ST_IDLE: begin
                if (i_cmd.start) begin
                    r_idx[0] <= i_first_index;
                    r_idx[1] <= i_second_index;
                    r_idx[2] <= i_third_index;
                    r_inr[0] <= 32'(i_first_index) < VERTEX_SLOTS;
                    r_inr[1] <= 32'(i_second_index) < VERTEX_SLOTS;
                    r_inr[2] <= 32'(i_third_index) < VERTEX_SLOTS;
                end
            end
            tcvl_pkg::ST_READ: begin
                if (i_cmd.cnt[1:0] != 2'd0) begin
                    for (int i = 0; i < 3; i++) begin
                        r_p[i_cmd.cnt[1:0] - 2'd1][i] <= r_inr[i_cmd.cnt[1:0] - 2'd1] ?
                            $signed(rdata[92 - 16 * i -: 16]) : 16'sd0;
                        r_vc[i_cmd.cnt[1:0] - 2'd1][i] <= r_inr[i_cmd.cnt[1:0] - 2'd1] ?
                            rdata[44 - 15 * i -: 15] : 15'd0;
                    end
                end
            end
            tcvl_pkg::ST_DIFF: begin
                for (int i = 0; i < 3; i++) begin
                    r_a[i] <= 17'(r_p[0][i]) - 17'(r_p[1][i]);
                    r_b[i] <= 17'(r_p[0][i]) - 17'(r_p[2][i]);
                end
            end
            tcvl_pkg::ST_CROSS: begin
                if (!i_cmd.cnt[0]) begin
                    r_pacc <= cprod;
                end else begin
                    r_n[i_cmd.cnt[2:1]] <= 35'(r_pacc) - 35'(cprod);
                end
            end
            tcvl_pkg::ST_MAG: begin
                for (int i = 0; i < 3; i++) begin
                    r_mag[i] <= 30'(absn[i] >> sh);
                    r_neg[i] <= r_n[i][34];
                end
                r_front <= r_n[2][34];
                r_sq    <= '0;
                r_sacc  <= '0;
            end
            tcvl_pkg::ST_SQ: begin
                r_sq  <= sqsum;
                r_x   <= 63'(sqsum);
                r_res <= '0;
            end
            tcvl_pkg::ST_SQRT: begin
                // track the root as it forms so the divide sees the final value
                if (r_x >= strial) begin
                    r_x   <= r_x - strial;
                    r_res <= (r_res >> 1) + sbit;
                    r_len <= 31'((r_res >> 1) + sbit);
                end else begin
                    r_res <= r_res >> 1;
                    r_len <= 31'(r_res >> 1);
                end
            end
            tcvl_pkg::ST_DIV: begin
                if (i_cmd.cnt == 6'd0) begin
                    if (i_cmd.comp == 2'd0) begin
                        r_len <= r_res[30:0];
                    end
                    r_rem <= 47'(dnum);
                    r_dsh <= {r_len, 1'b0, 15'd0};
                    r_q   <= '0;
                end else begin
                    if (dge) begin
                        r_rem <= r_rem - r_dsh;
                    end
                    r_dsh <= r_dsh >> 1;
                    r_q   <= dq_next;
                    if (i_cmd.cnt == 6'(tcvl_pkg::DIV_STEPS)) begin
                        if (r_len == '0) begin
                            r_u[i_cmd.comp] <= 16'sd0;
                        end else begin
                            r_u[i_cmd.comp] <= r_neg[i_cmd.comp] ?
                                -$signed(dq_clamp) : $signed(dq_clamp);
                        end
                    end
                end
            end
            tcvl_pkg::ST_SHADE: begin
                r_sacc  <= ssum;
                r_shade <= ssum[33] ? -$signed(20'(srnd)) : $signed(20'(srnd));
            end
            tcvl_pkg::ST_LIGHT: begin
                case (i_cmd.cnt[1:0])
                    2'd0: r_d <= lup[18:0];
                    2'd1: r_s <= lup[18:0];
                    2'd2: r_e <= lup[19:0];
                    2'd3: begin
                        if (ltot < 0) begin
                            r_col[i_cmd.comp] <= 15'd0;
                        end else if (ltot > 28'(tcvl_pkg::ONE_Q14)) begin
                            r_col[i_cmd.comp] <= 15'(tcvl_pkg::ONE_Q14);
                        end else begin
                            r_col[i_cmd.comp] <= ltot[14:0];
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // output register
    assign o_stat.out_free = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.op == tcvl_pkg::ST_EMIT && o_stat.out_free) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == tcvl_pkg::ST_EMIT && o_stat.out_free) begin
            o_screen_x         <= r_p[i_cmd.vtx][0];
            o_screen_y         <= r_p[i_cmd.vtx][1];
            o_shaded_red       <= r_col[0];
            o_shaded_green     <= r_col[1];
            o_shaded_blue      <= r_col[2];
            o_front_facing     <= r_front;
            o_last_of_triangle <= (i_cmd.vtx == 2'd2);
        end
    end

endmodule

@@ src/triangle_cull_and_vertex_light_core.sv @@
// Top level: back-face test and Gouraud vertex lighting over a vertex store.
// A load beat leaves the core in its idle state, so the core stays ready for the next beat.
// A draw beat holds the core busy through 4 store reads, 1 difference, 6 cross-product
// steps, 1 prescale, 3 squares, a 32-step square root, three divides, 3 shade steps,
// then 12 lighting steps and one emit per vertex; no new input beat is taken until
// the last emit, and each emit waits while the output register holds an unaccepted result.
// Synchronous active-low reset clears control and config; the store is not cleared.
module triangle_cull_and_vertex_light_core #(
    parameter int VERTEX_SLOTS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_opcode,
    input  logic [4:0]         i_vertex_index,
    input  logic signed [15:0] i_load_x,
    input  logic signed [15:0] i_load_y,
    input  logic signed [15:0] i_load_z,
    input  logic [14:0]        i_load_red,
    input  logic [14:0]        i_load_green,
    input  logic [14:0]        i_load_blue,
    input  logic [4:0]         i_first_index,
    input  logic [4:0]         i_second_index,
    input  logic [4:0]         i_third_index,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [47:0]        i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_screen_x,
    output logic signed [15:0] o_screen_y,
    output logic [14:0]        o_shaded_red,
    output logic [14:0]        o_shaded_green,
    output logic [14:0]        o_shaded_blue,
    output logic               o_front_facing,
    output logic               o_last_of_triangle
);

    tcvl_pkg::t_cmd  cmd;
    tcvl_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    // sequence control
    tcvl_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_opcode  (i_opcode),
        .o_in_ready(o_in_ready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    // arithmetic and storage
    tcvl_dp #(
        .VERTEX_SLOTS(VERTEX_SLOTS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_vertex_index    (i_vertex_index),
        .i_load_x          (i_load_x),
        .i_load_y          (i_load_y),
        .i_load_z          (i_load_z),
        .i_load_red        (i_load_red),
        .i_load_green      (i_load_green),
        .i_load_blue       (i_load_blue),
        .i_first_index     (i_first_index),
        .i_second_index    (i_second_index),
        .i_third_index     (i_third_index),
        .i_cfg_valid       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_screen_x        (o_screen_x),
        .o_screen_y        (o_screen_y),
        .o_shaded_red      (o_shaded_red),
        .o_shaded_green    (o_shaded_green),
        .o_shaded_blue     (o_shaded_blue),
        .o_front_facing    (o_front_facing),
        .o_last_of_triangle(o_last_of_triangle)
    );

`ifndef SYNTHESIS
    // a draw beat occupies the core on the next cycle
    a_draw_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_opcode) |=> !o_in_ready)
        else $error("core ready right after a draw beat");

    // colors stay within the saturation range
    a_color_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_shaded_red <= 15'd16384) && (o_shaded_green <= 15'd16384)
                        && (o_shaded_blue <= 15'd16384))
        else $error("shaded color beyond 1.0");

    // a result beat other than the last of its triangle appears only while the core is busy with a draw
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_out_valid) && !o_last_of_triangle) |-> !o_in_ready)
        else $error("result emitted while idle");
`endif

endmodule

@@ bench/tb.sv @@
// Testbench for the triangle cull and vertex light core: directed rows, then random beats.
module tb;

    localparam bit OP_LOAD = 1'b0;
    localparam bit OP_DRAW = 1'b1;
    localparam int SETTLE_CYCLES = 200;
    localparam longint CYCLE_LIMIT = 600000;

    typedef struct {
        bit          op;
        logic [4:0]  slot;
        logic [15:0] x, y, z;
        logic [14:0] r, g, b;
        logic [4:0]  i0, i1, i2;
        bit          typed;
        logic [14:0] rgb;
        bit          front;
    } t_stim_row;

    typedef struct {
        logic [15:0] x, y;
        logic [14:0] r, g, b;
        logic        front, last;
    } t_lit_vertex;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_opcode = 1'b0;
    logic [4:0] i_vertex_index = '0;
    logic signed [15:0] i_load_x = '0, i_load_y = '0, i_load_z = '0;
    logic [14:0] i_load_red = '0, i_load_green = '0, i_load_blue = '0;
    logic [4:0] i_first_index = '0, i_second_index = '0, i_third_index = '0;
    logic i_cfg_valid = 1'b0;
    logic [2:0] i_cfg_index = '0;
    logic [47:0] i_cfg_data = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready, o_cfg_ready, o_out_valid;
    logic signed [15:0] o_screen_x, o_screen_y;
    logic [14:0] o_shaded_red, o_shaded_green, o_shaded_blue;
    logic o_front_facing, o_last_of_triangle;

    triangle_cull_and_vertex_light_core DUT (.*);

    always #5 i_clk = ~i_clk;

    // shadow of the vertex store and light registers
    logic [15:0] pos_x [32], pos_y [32], pos_z [32];
    logic [14:0] col_r [32], col_g [32], col_b [32];
    bit          slot_loaded [32];
    logic [47:0] light_regs [6];

    t_lit_vertex lit_queue[$];
    int errors = 0;
    bit quiet = 1'b0;      // no random idling on either side while set
    bit hold_req = 1'b0;   // ask the sink for one long stall
    longint cycles = 0;

    function automatic longint fld(logic [47:0] reg_val, int k);
        return longint'(reg_val[47 - 16 * k -: 16]);
    endfunction

    function automatic longint sfld(logic [47:0] reg_val, int k);
        logic signed [15:0] v;
        v = reg_val[47 - 16 * k -: 16];
        return longint'(v);
    endfunction

    function automatic longint round_away14(longint v);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + 8192) >> 14;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint int_sqrt(longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    // compute the three lit vertices of a triangle and queue them
    function automatic void predict_triangle(logic [4:0] ia, logic [4:0] ib, logic [4:0] ic);
        logic [4:0] sl [3];
        longint p [3][3];
        longint a [3], b [3], n [3], u [3], mag [3];
        longint maxm, sq, len, q, shade, d, e, f, s, tot;
        logic [14:0] vc;
        int sh;
        bit front;
        t_lit_vertex o;
        sl[0] = ia; sl[1] = ib; sl[2] = ic;
        for (int v = 0; v < 3; v++) begin
            p[v][0] = longint'($signed(pos_x[sl[v]]));
            p[v][1] = longint'($signed(pos_y[sl[v]]));
            p[v][2] = longint'($signed(pos_z[sl[v]]));
        end
        for (int i = 0; i < 3; i++) begin
            a[i] = p[0][i] - p[1][i];
            b[i] = p[0][i] - p[2][i];
        end
        n[0] = a[1] * b[2] - a[2] * b[1];
        n[1] = a[2] * b[0] - a[0] * b[2];
        n[2] = a[0] * b[1] - a[1] * b[0];
        front = n[2] < 0;
        maxm = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (n[i] < 0) ? -n[i] : n[i];
            if (mag[i] > maxm) maxm = mag[i];
        end
        sh = 0;
        while ((maxm >> sh) >= (64'd1 << 30)) sh++;
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = mag[i] >> sh;
            sq += mag[i] * mag[i];
        end
        len = int_sqrt(sq);
        shade = 0;
        for (int i = 0; i < 3; i++) begin
            q = 0;
            if (len != 0) begin
                q = (mag[i] * 2 * tcvl_pkg::ONE_Q14 + len) / (2 * len);
                if (q > tcvl_pkg::ONE_Q14) q = tcvl_pkg::ONE_Q14;
            end
            u[i] = (n[i] < 0) ? -q : q;
            shade += sfld(light_regs[tcvl_pkg::CFG_LIGHT_DIR], i) * u[i];
        end
        shade = round_away14(shade);
        for (int v = 0; v < 3; v++) begin
            o.x = pos_x[sl[v]];
            o.y = pos_y[sl[v]];
            for (int i = 0; i < 3; i++) begin
                vc = (i == 0) ? col_r[sl[v]] : (i == 1) ? col_g[sl[v]] : col_b[sl[v]];
                d = (fld(light_regs[tcvl_pkg::CFG_LDIFFUSE], i)
                     * fld(light_regs[tcvl_pkg::CFG_MDIFFUSE], i) + 8192) >> 14;
                e = (d * longint'(vc) + 8192) >> 14;
                f = round_away14(e * shade);
                s = (fld(light_regs[tcvl_pkg::CFG_LSPECULAR], i)
                     * fld(light_regs[tcvl_pkg::CFG_MSPECULAR], i) + 8192) >> 14;
                tot = fld(light_regs[tcvl_pkg::CFG_AMBIENT], i) + f + s;
                if (tot < 0) tot = 0;
                if (tot > tcvl_pkg::ONE_Q14) tot = tcvl_pkg::ONE_Q14;
                if (i == 0) o.r = tot[14:0];
                else if (i == 1) o.g = tot[14:0];
                else o.b = tot[14:0];
            end
            o.front = front;
            o.last = (v == 2);
            lit_queue.push_back(o);
        end
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // send one input beat after a random gap unless quiet, then update the shadow or predict
    task automatic send_beat(t_stim_row row);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_opcode = row.op;
        i_vertex_index = row.slot;
        i_load_x = row.x; i_load_y = row.y; i_load_z = row.z;
        i_load_red = row.r; i_load_green = row.g; i_load_blue = row.b;
        i_first_index = row.i0; i_second_index = row.i1; i_third_index = row.i2;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        if (row.op == OP_LOAD) begin
            pos_x[row.slot] = row.x; pos_y[row.slot] = row.y; pos_z[row.slot] = row.z;
            col_r[row.slot] = row.r; col_g[row.slot] = row.g; col_b[row.slot] = row.b;
            slot_loaded[row.slot] = 1'b1;
        end else begin
            predict_triangle(row.i0, row.i1, row.i2);
            if (row.typed) begin
                for (int k = lit_queue.size() - 3; k < lit_queue.size(); k++) begin
                    lit_queue[k].r = row.rgb;
                    lit_queue[k].g = row.rgb;
                    lit_queue[k].b = row.rgb;
                    lit_queue[k].front = row.front;
                end
            end
        end
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [47:0] data);
        i_cfg_index = idx;
        i_cfg_data = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx < 6) light_regs[idx] = data;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // drain results, then let the core finish any work in flight
    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (lit_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic t_stim_row load_row(logic [4:0] slot, logic [15:0] x, logic [15:0] y,
                                           logic [15:0] z, logic [14:0] c);
        t_stim_row row;
        row = '{default: '0};
        row.op = OP_LOAD; row.slot = slot;
        row.x = x; row.y = y; row.z = z;
        row.r = c; row.g = c; row.b = c;
        return row;
    endfunction

    function automatic t_stim_row draw_row(logic [4:0] a, logic [4:0] b, logic [4:0] c,
                                           bit typed, logic [14:0] rgb, bit front);
        t_stim_row row;
        row = '{default: '0};
        row.op = OP_DRAW; row.i0 = a; row.i1 = b; row.i2 = c;
        row.typed = typed; row.rgb = rgb; row.front = front;
        return row;
    endfunction

    function automatic logic [4:0] pick_loaded();
        logic [4:0] s;
        do s = 5'($urandom_range(0, 31)); while (!slot_loaded[s]);
        return s;
    endfunction

    function automatic t_stim_row random_row();
        t_stim_row row;
        row = '{default: '0};
        row.op = ($urandom_range(0, 99) < 35) ? OP_LOAD : OP_DRAW;
        if (row.op == OP_LOAD) begin
            row.slot = 5'($urandom_range(0, 31));
            row.x = 16'($urandom); row.y = 16'($urandom); row.z = 16'($urandom);
            if ($urandom_range(0, 4) == 0) begin
                row.r = 15'($urandom); row.g = 15'($urandom); row.b = 15'($urandom);
            end else begin
                row.r = 15'($urandom_range(0, tcvl_pkg::ONE_Q14));
                row.g = 15'($urandom_range(0, tcvl_pkg::ONE_Q14));
                row.b = 15'($urandom_range(0, tcvl_pkg::ONE_Q14));
            end
        end else begin
            row.i0 = pick_loaded();
            row.i1 = pick_loaded();
            row.i2 = ($urandom_range(0, 9) == 0) ? row.i0 : pick_loaded();
        end
        return row;
    endfunction

    function automatic logic [47:0] rand_rgb();
        return {16'($urandom_range(0, tcvl_pkg::ONE_Q14)),
                16'($urandom_range(0, tcvl_pkg::ONE_Q14)),
                16'($urandom_range(0, tcvl_pkg::ONE_Q14))};
    endfunction

    // result side: random stalls, one long hold on request, compare each beat
    initial begin
        int stall;
        t_lit_vertex want;
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 12);
            if (hold_req) begin
                stall = 800;
                hold_req = 1'b0;
            end
            if (stall > 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            if (lit_queue.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                want = lit_queue.pop_front();
                if (o_screen_x !== want.x) report_mismatch("screen_x", o_screen_x, want.x);
                if (o_screen_y !== want.y) report_mismatch("screen_y", o_screen_y, want.y);
                if (o_shaded_red !== want.r) report_mismatch("red", o_shaded_red, want.r);
                if (o_shaded_green !== want.g) report_mismatch("green", o_shaded_green, want.g);
                if (o_shaded_blue !== want.b) report_mismatch("blue", o_shaded_blue, want.b);
                if (o_front_facing !== want.front)
                    report_mismatch("front", o_front_facing, want.front);
                if (o_last_of_triangle !== want.last)
                    report_mismatch("last", o_last_of_triangle, want.last);
            end
            @(negedge i_clk);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        t_stim_row directed[$];
        logic [47:0] cfg_set [6];
        light_regs[tcvl_pkg::CFG_LIGHT_DIR] = tcvl_pkg::RST_LIGHT_DIR;
        light_regs[tcvl_pkg::CFG_AMBIENT]   = '0;
        light_regs[tcvl_pkg::CFG_LDIFFUSE]  = tcvl_pkg::RST_ONES;
        light_regs[tcvl_pkg::CFG_LSPECULAR] = '0;
        light_regs[tcvl_pkg::CFG_MDIFFUSE]  = tcvl_pkg::RST_ONES;
        light_regs[tcvl_pkg::CFG_MSPECULAR] = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows under reset lighting: light along -z, unit diffuse
        directed.push_back(load_row(0, 16'd0, 16'd0, 16'd0, 15'd16384));
        directed.push_back(load_row(1, -16'sd16, 16'd0, 16'd0, 15'd16384));
        directed.push_back(load_row(2, 16'd0, 16'd16, 16'd0, 15'd16384));
        directed.push_back(draw_row(0, 1, 2, 1'b1, 15'd16384, 1'b1));
        directed.push_back(draw_row(0, 2, 1, 1'b1, 15'd0, 1'b0));
        directed.push_back(draw_row(0, 0, 0, 1'b1, 15'd0, 1'b0));
        directed.push_back(draw_row(0, 1, 1, 1'b1, 15'd0, 1'b0));
        directed.push_back(load_row(3, 16'h7FFF, 16'h7FFF, 16'h7FFF, 15'h7FFF));
        directed.push_back(load_row(4, 16'h8000, 16'h8000, 16'h8000, 15'd0));
        directed.push_back(load_row(5, 16'h7FFF, 16'h8000, 16'd0, 15'h5555));
        directed.push_back(load_row(31, 16'h8000, 16'h7FFF, 16'h7FFF, 15'h2AAA));
        directed.push_back(draw_row(3, 4, 5, 1'b0, 15'd0, 1'b0));
        directed.push_back(draw_row(5, 31, 3, 1'b0, 15'd0, 1'b0));
        directed.push_back(draw_row(31, 4, 3, 1'b0, 15'd0, 1'b0));
        directed.push_back(draw_row(3, 4, 31, 1'b0, 15'd0, 1'b0));
        directed.push_back(draw_row(1, 3, 4, 1'b0, 15'd0, 1'b0));
        foreach (directed[k]) send_beat(directed[k]);
        wait_idle();

        // lighting phases: maxima, zeros, then random settings
        for (int ph = 0; ph < 5; ph++) begin
            for (int r = 0; r < 6; r++) begin
                case (ph)
                    0: cfg_set[r] = '1;
                    1: cfg_set[r] = '0;
                    2: cfg_set[r] = 48'({$urandom, $urandom});
                    default: cfg_set[r] = (r == tcvl_pkg::CFG_LIGHT_DIR) ?
                        {16'($urandom), 16'($urandom), 16'($urandom)} : rand_rgb();
                endcase
            end
            for (int r = 0; r < 8; r++)
                write_reg(r[2:0], (r < 6) ? cfg_set[r] : 48'({$urandom, $urandom}));
            if (ph == 3) hold_req = 1'b1;
            for (int k = 0; k < 64; k++) begin
                quiet = (k % 40) < 10;
                send_beat(random_row());
            end
            quiet = 1'b0;
            wait_idle();
        end

        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
src/tcvl_pkg.sv
src/tcvl_ram.sv
src/tcvl_ctrl.sv
src/tcvl_dp.sv
src/triangle_cull_and_vertex_light_core.sv
bench/tb.sv
